// ===== sv/aafc_pkg.sv =====
// Shared types and constants for the box frustum/clip classifier.
// Word layouts, register indexes and field positions; depends on nothing.
package aafc_pkg;

  localparam int CoordBits  = 16;
  localparam int CoefBits   = 16;
  localparam int CoefFrac   = 14;
  localparam int PlaneBits  = 64;
  localparam int MaxPlanes  = 6;
  localparam int ProdBits   = CoefBits + CoordBits;
  localparam int SumBits    = ProdBits + 2;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = 64;

  localparam int ClipSetupBits = 54;
  localparam int ClipFlipLsb   = 48;
  localparam int ClipEnLsb     = 51;

  localparam int PLANE_COUNT_DEF = MaxPlanes;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PLANE_0    = 3'd0,
    CFG_PLANE_1    = 3'd1,
    CFG_PLANE_2    = 3'd2,
    CFG_PLANE_3    = 3'd3,
    CFG_PLANE_4    = 3'd4,
    CFG_PLANE_5    = 3'd5,
    CFG_CLIP_SETUP = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAP_X   = 2'd0,
    CAP_Y   = 2'd1,
    CAP_Z   = 2'd2,
    CAP_ALL = 2'd3
  } cap_axis_t;

  typedef struct packed {
    logic                        box_present;
    logic signed [CoordBits-1:0] x_lo;
    logic signed [CoordBits-1:0] x_hi;
    logic signed [CoordBits-1:0] y_lo;
    logic signed [CoordBits-1:0] y_hi;
    logic signed [CoordBits-1:0] z_lo;
    logic signed [CoordBits-1:0] z_hi;
    logic [1:0]                  cap_axis;
  } in_word_t;

  typedef struct packed {
    logic frustum_outside;
    logic frustum_inside;
    logic clipped_x;
    logic clipped_y;
    logic clipped_z;
    logic kept_x;
    logic kept_y;
    logic kept_z;
    logic straddles_cap;
    logic hidden_all_passes;
  } out_word_t;

  // Per-axis clip results carried alongside the plane pipeline.
  typedef struct packed {
    logic       present;
    logic [2:0] clipped;
    logic [2:0] kept;
    logic       straddle;
    logic       hidden;
  } axis_flags_t;

endpackage

// ===== sv/aabb_frustum_clip_classifier.sv =====
// Top level of the box frustum/clip classifier: config registers, axis tests,
// valid pipeline and result register. Uses aafc_pkg and aafc_plane_eval.
//
// Usage
//   Input: drive in_data with start high; the word is taken at any rising
//   edge where start is high and busy is low. busy is high while reset is
//   applied and drops at the first rising edge with rst_n high, so from then
//   on one box per cycle is taken.
//   Output: out_valid strobes for exactly one cycle with out_data; the
//   receiver must take the word in that cycle, there is no back-pressure.
//   Config: cfg_we with cfg_idx/cfg_data writes plane 0..5 or clip setup;
//   index 7 and planes at or above PLANE_COUNT are dropped. Write
//   only while no boxes are in flight.
//   Pipeline: a taken box passes three register stages (corner select,
//   multiply, sum and result) before out_valid strobes with its word.
//   Throughput: one box per cycle, fixed by the plane evaluators, each with
//   six 16x16 multipliers working on every cycle.
//   Reset: rst_n low clears the valid pipeline and the configuration
//   registers to zero; words in flight are dropped.
//   An absent box (box_present low) still occupies one slot and returns the
//   fixed defaults: outside, clipped and hidden set, all others clear.
module aabb_frustum_clip_classifier #(
  parameter int PLANE_COUNT = aafc_pkg::PLANE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  aafc_pkg::in_word_t              in_data,
  output logic                            out_valid,
  output aafc_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [aafc_pkg::CfgIdxBits-1:0] cfg_idx,
  input  logic [aafc_pkg::CfgBits-1:0]    cfg_data
);
  import aafc_pkg::*;

  logic                     busy_r;
  logic [PlaneBits-1:0]     plane_r [PLANE_COUNT];
  logic [ClipSetupBits-1:0] clip_r;

  logic                        in_accept;
  logic signed [CoordBits-1:0] lo [3];
  logic signed [CoordBits-1:0] hi [3];
  logic signed [CoordBits-1:0] thr [3];
  axis_flags_t                 flags_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  axis_flags_t s1_flags_r;
  logic        s2_valid_r, s2_valid_nxt;
  axis_flags_t s2_flags_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic [PLANE_COUNT-1:0] pos_below;
  logic [PLANE_COUNT-1:0] neg_below;

  assign in_accept = start && !busy_r;
  assign busy      = busy_r;

  // Hold busy through reset so nothing is taken into a clearing pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration: planes below PLANE_COUNT are stored, others dropped.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        plane_r[p] <= '0;
      end else if (cfg_we && cfg_idx == CfgIdxBits'(p)) begin
        plane_r[p] <= cfg_data;
      end
    end

    aafc_plane_eval u_plane (
      .clk       (clk),
      .plane     (plane_r[p]),
      .box       (in_data),
      .pos_below (pos_below[p]),
      .neg_below (neg_below[p])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= '0;
    end else if (cfg_we && cfg_idx == CFG_CLIP_SETUP) begin
      clip_r <= cfg_data[ClipSetupBits-1:0];
    end
  end

  // Stage 1: per-axis threshold tests, cap straddle and hidden flag.
  always_comb begin
    lo[0] = in_data.x_lo;  hi[0] = in_data.x_hi;
    lo[1] = in_data.y_lo;  hi[1] = in_data.y_hi;
    lo[2] = in_data.z_lo;  hi[2] = in_data.z_hi;
    flags_nxt         = '0;
    flags_nxt.present = in_data.box_present;
    flags_nxt.hidden  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      thr[i] = clip_r[CoordBits*i +: CoordBits];
      if (clip_r[ClipFlipLsb+i]) begin
        flags_nxt.clipped[i] = hi[i] < thr[i];
        flags_nxt.kept[i]    = lo[i] >= thr[i];
      end else begin
        flags_nxt.clipped[i] = lo[i] > thr[i];
        flags_nxt.kept[i]    = hi[i] <= thr[i];
      end
      // Any enabled pass that keeps part of the box makes it visible.
      if (clip_r[ClipEnLsb+i] && !flags_nxt.clipped[i]) begin
        flags_nxt.hidden = 1'b0;
      end
    end
    case (in_data.cap_axis)
      CAP_X:   flags_nxt.straddle = !flags_nxt.clipped[0] && !flags_nxt.kept[0];
      CAP_Y:   flags_nxt.straddle = !flags_nxt.clipped[1] && !flags_nxt.kept[1];
      CAP_Z:   flags_nxt.straddle = !flags_nxt.clipped[2] && !flags_nxt.kept[2];
      default: flags_nxt.straddle = 1'b1;
    endcase
  end

  // Valid bits advance every cycle; the receiver cannot stall.
  assign s1_valid_nxt  = in_accept;
  assign s2_valid_nxt  = s1_valid_r;
  assign out_valid_nxt = s2_valid_r;

  // Stage 3: fold the plane signs and apply the absent-box defaults.
  always_comb begin
    out_data_nxt.frustum_outside   = |pos_below;
    out_data_nxt.frustum_inside    = ~|neg_below;
    out_data_nxt.clipped_x         = s2_flags_r.clipped[0];
    out_data_nxt.clipped_y         = s2_flags_r.clipped[1];
    out_data_nxt.clipped_z         = s2_flags_r.clipped[2];
    out_data_nxt.kept_x            = s2_flags_r.kept[0];
    out_data_nxt.kept_y            = s2_flags_r.kept[1];
    out_data_nxt.kept_z            = s2_flags_r.kept[2];
    out_data_nxt.straddles_cap     = s2_flags_r.straddle;
    out_data_nxt.hidden_all_passes = s2_flags_r.hidden;
    if (!s2_flags_r.present) begin
      out_data_nxt.frustum_outside   = 1'b1;
      out_data_nxt.frustum_inside    = 1'b0;
      out_data_nxt.clipped_x         = 1'b1;
      out_data_nxt.clipped_y         = 1'b1;
      out_data_nxt.clipped_z         = 1'b1;
      out_data_nxt.kept_x            = 1'b0;
      out_data_nxt.kept_y            = 1'b0;
      out_data_nxt.kept_z            = 1'b0;
      out_data_nxt.straddles_cap     = 1'b0;
      out_data_nxt.hidden_all_passes = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_flags_r <= flags_nxt;
    s2_flags_r <= s1_flags_r;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Every taken box returns as an out_valid strobe.
  a_accept_returns : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##3 out_valid)
    else $error("accepted box did not return after three cycles");

  a_no_invented : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, 3))
    else $error("result strobe without a matching accepted box");

  // A strobed word always carries fully defined flags.
  a_out_known : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result word carries undefined flags");
`endif

endmodule

// ===== sv/aafc_plane_eval.sv =====
// One frustum plane: support corner select, multiply, sum and sign.
// Two register stages, sign bits leave combinationally; uses aafc_pkg.
module aafc_plane_eval (
  input  logic                             clk,
  input  logic [aafc_pkg::PlaneBits-1:0]   plane,
  input  aafc_pkg::in_word_t               box,
  output logic                             pos_below,
  output logic                             neg_below
);
  import aafc_pkg::*;

  logic signed [CoefBits-1:0]  coef [3];
  logic signed [CoefBits-1:0]  coef_d;
  logic signed [CoordBits-1:0] lo [3];
  logic signed [CoordBits-1:0] hi [3];

  logic signed [CoordBits-1:0] pos_r [3];
  logic signed [CoordBits-1:0] pos_nxt [3];
  logic signed [CoordBits-1:0] neg_r [3];
  logic signed [CoordBits-1:0] neg_nxt [3];
  logic signed [ProdBits-1:0]  prod_pos_r [3];
  logic signed [ProdBits-1:0]  prod_pos_nxt [3];
  logic signed [ProdBits-1:0]  prod_neg_r [3];
  logic signed [ProdBits-1:0]  prod_neg_nxt [3];
  logic signed [SumBits-1:0]   d_term;
  logic signed [SumBits-1:0]   sum_pos;
  logic signed [SumBits-1:0]   sum_neg;

  always_comb begin
    coef[0] = plane[CoefBits-1:0];
    coef[1] = plane[2*CoefBits-1:CoefBits];
    coef[2] = plane[3*CoefBits-1:2*CoefBits];
    coef_d  = plane[4*CoefBits-1:3*CoefBits];
    lo[0] = box.x_lo;  hi[0] = box.x_hi;
    lo[1] = box.y_lo;  hi[1] = box.y_hi;
    lo[2] = box.z_lo;  hi[2] = box.z_hi;
  end

  // Positive corner takes hi where the normal component is non-negative.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = coef[i][CoefBits-1] ? lo[i] : hi[i];
      neg_nxt[i] = coef[i][CoefBits-1] ? hi[i] : lo[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_pos_nxt[i] = coef[i] * pos_r[i];
      prod_neg_nxt[i] = coef[i] * neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    neg_r      <= neg_nxt;
    prod_pos_r <= prod_pos_nxt;
    prod_neg_r <= prod_neg_nxt;
  end

  // Exact sum: products plus d scaled up to the Q1.14 grid.
  always_comb begin
    d_term  = SumBits'(coef_d) <<< CoefFrac;
    sum_pos = SumBits'(prod_pos_r[0]) + SumBits'(prod_pos_r[1])
            + SumBits'(prod_pos_r[2]) + d_term;
    sum_neg = SumBits'(prod_neg_r[0]) + SumBits'(prod_neg_r[1])
            + SumBits'(prod_neg_r[2]) + d_term;
  end

  assign pos_below = sum_pos[SumBits-1];
  assign neg_below = sum_neg[SumBits-1];

endmodule

// ===== sim/tb_aabb_frustum_clip_classifier.sv =====
// Self-checking testbench for the box frustum/clip classifier.
// Uses aafc_pkg for word layouts and register indexes; drives the top level directly.
module tb_aabb_frustum_clip_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import aafc_pkg::*;

  localparam int                  ResetCycles  = 7;
  localparam int                  DrainCycles  = 8;
  localparam int                  ReconfigStep = 50;
  localparam logic [CfgIdxBits-1:0] CfgIdxSpare = 3'd7;  // unmapped register index

  // Drive every input to a known value from time zero.
  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  start    = 1'b0;
  logic                  busy;
  in_word_t              in_data  = '0;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx  = '0;
  logic [CfgBits-1:0]    cfg_data = '0;

  // Shadow copy of the block's registers, kept in step with every write.
  logic [PlaneBits-1:0]     plane_regs [MaxPlanes];
  logic [ClipSetupBits-1:0] clip_regs;

  out_word_t expected_flags[$];
  int        err_count = 0;
  int        idle_pct  = 0;

  // Field names indexed from the most significant bit of out_word_t down.
  string field_names [10] = '{"frustum_outside", "frustum_inside", "clipped_x",
                              "clipped_y", "clipped_z", "kept_x", "kept_y", "kept_z",
                              "straddles_cap", "hidden_all_passes"};

  always #5 clk = ~clk;

  aabb_frustum_clip_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  // Predict the flags of one box from the shadow registers.
  function automatic out_word_t classify_box(in_word_t w);
    out_word_t   r;
    longint      lo [3];
    longint      hi [3];
    longint      coef [3];
    longint      pos_pt [3];
    longint      neg_pt [3];
    longint      offset, v_pos, v_neg, thr;
    logic [63:0] p;
    logic [2:0]  clipped, kept;
    logic        flip;
    r = '0;
    // An absent box gives the fixed defaults and ignores the coordinates.
    if (!w.box_present) begin
      r.frustum_outside   = 1'b1;
      r.clipped_x         = 1'b1;
      r.clipped_y         = 1'b1;
      r.clipped_z         = 1'b1;
      r.hidden_all_passes = 1'b1;
      return r;
    end
    lo[0] = w.x_lo;  hi[0] = w.x_hi;
    lo[1] = w.y_lo;  hi[1] = w.y_hi;
    lo[2] = w.z_lo;  hi[2] = w.z_hi;
    r.frustum_inside = 1'b1;
    for (int i = 0; i < PLANE_COUNT_DEF; i++) begin
      p = plane_regs[i];
      // Pick the positive and negative support corners by normal sign.
      for (int k = 0; k < 3; k++) begin
        coef[k]   = $signed(p[16*k +: 16]);
        pos_pt[k] = (coef[k] >= 0) ? hi[k] : lo[k];
        neg_pt[k] = (coef[k] >= 0) ? lo[k] : hi[k];
      end
      offset = $signed(p[63:48]);
      offset = offset * 16384;
      v_pos = coef[0] * pos_pt[0] + coef[1] * pos_pt[1] + coef[2] * pos_pt[2] + offset;
      v_neg = coef[0] * neg_pt[0] + coef[1] * neg_pt[1] + coef[2] * neg_pt[2] + offset;
      if (v_pos < 0) r.frustum_outside = 1'b1;
      if (v_neg < 0) r.frustum_inside  = 1'b0;
    end
    r.hidden_all_passes = 1'b1;
    for (int i = 0; i < 3; i++) begin
      thr        = $signed(clip_regs[16*i +: 16]);
      flip       = clip_regs[ClipFlipLsb + i];
      clipped[i] = flip ? (hi[i] < thr)  : (lo[i] > thr);
      kept[i]    = flip ? (lo[i] >= thr) : (hi[i] <= thr);
      if (clip_regs[ClipEnLsb + i] && !clipped[i]) r.hidden_all_passes = 1'b0;
    end
    r.clipped_x = clipped[0];
    r.clipped_y = clipped[1];
    r.clipped_z = clipped[2];
    r.kept_x    = kept[0];
    r.kept_y    = kept[1];
    r.kept_z    = kept[2];
    if (w.cap_axis == CAP_ALL) r.straddles_cap = 1'b1;
    else r.straddles_cap = !clipped[w.cap_axis] && !kept[w.cap_axis];
    return r;
  endfunction

  function automatic logic [63:0] pack_plane(logic signed [15:0] a, logic signed [15:0] b,
                                             logic signed [15:0] c, logic signed [15:0] d);
    return {d, c, b, a};
  endfunction

  function automatic logic [63:0] pack_clip(logic signed [15:0] tx, logic signed [15:0] ty,
                                            logic signed [15:0] tz, logic [2:0] flip,
                                            logic [2:0] en);
    // Set the spare top bits so that their masking is exercised too.
    return {10'($urandom), en, flip, tz, ty, tx};
  endfunction

  function automatic in_word_t mk_box(logic present, int xl, int xh, int yl, int yh,
                                      int zl, int zh, cap_axis_t cap);
    in_word_t w;
    w.box_present = present;
    w.x_lo = 16'(xl);  w.x_hi = 16'(xh);
    w.y_lo = 16'(yl);  w.y_hi = 16'(yh);
    w.z_lo = 16'(zl);  w.z_hi = 16'(zh);
    w.cap_axis = cap;
    return w;
  endfunction

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(6))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sd0;
      3:       return 16'sd16384;
      4:       return -16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offsets and thresholds mostly near the boxes, sometimes anywhere.
  function automatic logic signed [15:0] rand_level();
    if ($urandom_range(4) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(8000)) - 4000);
  endfunction

  function automatic void rand_span(output int lo, output int hi);
    int mid, ext;
    case ($urandom_range(9))
      0: begin
        // Fully random, inverted half the time.
        lo = int'(16'($urandom));
        hi = int'(16'($urandom));
      end
      1: begin
        lo = $urandom_range(1) ? 32767 : -32768;
        hi = $urandom_range(1) ? 32767 : -32768;
      end
      default: begin
        mid = int'($urandom_range(8000)) - 4000;
        ext = $urandom_range(2000);
        lo  = mid - ext;
        hi  = mid + ext;
      end
    endcase
  endfunction

  function automatic in_word_t rand_box();
    int lo [3];
    int hi [3];
    for (int k = 0; k < 3; k++) rand_span(lo[k], hi[k]);
    return mk_box($urandom_range(15) != 0, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                  cap_axis_t'($urandom_range(3)));
  endfunction

  // Write one register; the block must be idle.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_PLANE_5) plane_regs[idx] = val;
    else if (idx == CFG_CLIP_SETUP) clip_regs = val[ClipSetupBits-1:0];
  endtask

  // Offer one word, idling first at the current rate; hold it until taken.
  task automatic send_box(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    expected_flags.push_back(classify_box(w));
  endtask

  // Drop start, wait for every pending word, then let the pipeline empty.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_config();
    for (int i = 0; i < MaxPlanes; i++)
      write_reg(3'(i), pack_plane(rand_coef(), rand_coef(), rand_coef(), rand_level()));
    write_reg(CFG_CLIP_SETUP, pack_clip(rand_level(), rand_level(), rand_level(),
                                        3'($urandom), 3'($urandom)));
    if ($urandom_range(3) == 0) write_reg(CfgIdxSpare, {$urandom, $urandom});
  endtask

  // All registers are zero after reset: every plane sums to zero.
  task automatic test_reset_state();
    idle_pct = 0;
    send_box(mk_box(1'b1, -5, 5, -5, 5, -5, 5, CAP_X));
    send_box(mk_box(1'b1, 100, 200, -300, -200, 7, 9, CAP_Y));
    send_box(mk_box(1'b0, 0, 0, 0, 0, 0, 0, CAP_Z));
    send_box(mk_box(1'b1, -1, 1, 1, -1, 0, 0, CAP_ALL));
    drain_results();
  endtask

  task automatic test_directed();
    idle_pct = 0;
    // Cube frustum of half-width 1000 around the origin.
    write_reg(CFG_PLANE_0, pack_plane(16384, 0, 0, 1000));
    write_reg(CFG_PLANE_1, pack_plane(-16384, 0, 0, 1000));
    write_reg(CFG_PLANE_2, pack_plane(0, 16384, 0, 1000));
    write_reg(CFG_PLANE_3, pack_plane(0, -16384, 0, 1000));
    write_reg(CFG_PLANE_4, pack_plane(0, 0, 16384, 1000));
    write_reg(CFG_PLANE_5, pack_plane(0, 0, -16384, 1000));
    write_reg(CFG_CLIP_SETUP, pack_clip(0, 100, -100, 3'b010, 3'b111));
    // The spare index must leave every register untouched.
    write_reg(CfgIdxSpare, '1);
    send_box(mk_box(1'b0, 32767, -32768, 32767, -32768, 0, 0, CAP_ALL));
    send_box(mk_box(1'b1, -10, 10, -10, 10, -10, 10, CAP_X));
    send_box(mk_box(1'b1, 2000, 3000, 0, 5, 0, 5, CAP_Y));
    send_box(mk_box(1'b1, 900, 1100, -5, 5, -5, 5, CAP_Z));
    send_box(mk_box(1'b1, -32768, 32767, -32768, 32767, -32768, 32767, CAP_ALL));
    send_box(mk_box(1'b1, 32767, 32767, 32767, 32767, 32767, 32767, CAP_X));
    send_box(mk_box(1'b1, -32768, -32768, -32768, -32768, -32768, -32768, CAP_Y));
    // Inverted box: used as given.
    send_box(mk_box(1'b1, 500, -500, 300, -300, 200, -200, CAP_Z));
    // A box sitting exactly on each threshold, then one just beside them.
    send_box(mk_box(1'b1, 0, 0, 100, 100, -100, -100, CAP_X));
    send_box(mk_box(1'b1, 1, 5, 50, 99, -99, -50, CAP_Y));
    drain_results();

    // Extreme thresholds, x and z flipped, no pass enabled.
    write_reg(CFG_CLIP_SETUP, pack_clip(32767, -32768, 0, 3'b101, 3'b000));
    send_box(mk_box(1'b1, -32768, 32767, -32768, 32767, -32768, 32767, CAP_X));
    send_box(mk_box(1'b1, 32767, 32767, -32768, -32768, 0, 0, CAP_Y));
    send_box(mk_box(1'b1, -40, 40, 10, 20, -1, 1, CAP_Z));
    send_box(mk_box(1'b0, 1, 2, 3, 4, 5, 6, CAP_X));
    drain_results();

    write_reg(CFG_CLIP_SETUP, pack_clip(-32768, 32767, -32768, 3'b010, 3'b010));
    send_box(mk_box(1'b1, -32768, -32768, 32767, 32767, -32768, 32767, CAP_Y));
    send_box(mk_box(1'b1, 0, 10, -20, 32766, 5, 6, CAP_ALL));
    drain_results();

    // Extreme plane coefficients and offsets.
    write_reg(CFG_PLANE_0, pack_plane(-32768, 32767, -32768, -32768));
    write_reg(CFG_PLANE_1, pack_plane(32767, -32768, 32767, 32767));
    for (int i = CFG_PLANE_2; i <= CFG_PLANE_5; i++) write_reg(3'(i), '0);
    send_box(mk_box(1'b1, -32768, 32767, -32768, 32767, -32768, 32767, CAP_X));
    send_box(mk_box(1'b1, 32767, 32767, -32768, -32768, 32767, 32767, CAP_Y));
    send_box(mk_box(1'b1, -32768, -32768, 32767, 32767, -32768, -32768, CAP_Z));
    send_box(mk_box(1'b1, 0, 0, 0, 0, 0, 0, CAP_ALL));
    drain_results();
  endtask

  // Random boxes at one sender idle rate, reconfiguring at regular steps.
  task automatic test_random_traffic(int pct, int count);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      if (n % ReconfigStep == 0) begin
        if (n != 0) drain_results();
        random_config();
      end
      send_box(rand_box());
    end
    drain_results();
  endtask

  // Compare each strobed word against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_flags.size() == 0) begin
        $error("result word with no prediction pending: %b", out_data);
        err_count++;
      end else begin
        want = expected_flags.pop_front();
        for (int b = 0; b < 10; b++) begin
          if (out_data[9-b] !== want[9-b]) begin
            $error("%s: expected %0b, got %0b", field_names[b], want[9-b], out_data[9-b]);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : run_tests
    for (int i = 0; i < MaxPlanes; i++) plane_regs[i] = '0;
    clip_regs = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed();
    // Sender idle rates: none, heavy, light. The receiver cannot stall.
    test_random_traffic(0, 250);
    test_random_traffic(67, 250);
    test_random_traffic(17, 250);
    if (err_count == 0) begin
      $display("aabb_frustum_clip_classifier verification clean");
    end else begin
      $display("aabb_frustum_clip_classifier verification failed");
    end
    $finish;
  end

  // Hold a hard limit well beyond the slowest correct run.
  initial begin : watchdog
    #1ms;
    $display("aabb_frustum_clip_classifier verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aafc_pkg.sv
sv/aafc_plane_eval.sv
sv/aabb_frustum_clip_classifier.sv
sim/tb_aabb_frustum_clip_classifier.sv
